FILE: hw/rtl/nixie_blend_compositor_assert.svh
// Assertion macros for the nixie blend compositor checker.
// Expects clk and arst_n in the scope of use.
`ifndef NIXIE_BLEND_COMPOSITOR_ASSERT_SVH
`define NIXIE_BLEND_COMPOSITOR_ASSERT_SVH

// same-cycle implication
`define NBC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nbc: assertion failed");

// next-cycle implication
`define NBC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nbc: assertion failed");

`endif

FILE: hw/rtl/nbc_pkg.sv
// Shared types, codes and constants of the nixie blend compositor.
// No dependencies.
package nbc_pkg;

	localparam int WORD_W    = 64;
	localparam int OP_W      = 2;
	localparam int CHAN_W    = 2;
	localparam int DIS_W     = 6;
	localparam int FLAG_W    = 2;
	localparam int CNT_W     = 11;
	localparam int SLICE_W   = 6;
	localparam int SHIFT_W   = 4;
	localparam int DIGIT_W   = 4;
	localparam int LEVEL_W   = 10;
	localparam int PERIOD_W  = 12;
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 12;
	localparam int AP_POS    = 3;
	localparam int BIT_IDX_W = 6;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_TICK    = 2'd0;
	localparam op_t OP_LOAD    = 2'd1;
	localparam op_t OP_ADVANCE = 2'd2;
	localparam op_t OP_SET_DIS = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_AP_LEVEL    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AP_PERIOD   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HT_LOW      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BLEND_SHIFT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FAST_SLICES = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FAST_PHASES = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_SLICES = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_PHASES = 3'd7;

	localparam logic [LEVEL_W-1:0]  RST_AP_LEVEL    = 10'd0;
	localparam logic [PERIOD_W-1:0] RST_AP_PERIOD   = 12'd1000;
	localparam logic [DIGIT_W-1:0]  RST_HT_LOW      = 4'd3;
	localparam logic [SHIFT_W-1:0]  RST_BLEND_SHIFT = 4'd1;
	localparam logic [SLICE_W-1:0]  RST_FAST_SLICES = 6'd12;
	localparam logic [SLICE_W-1:0]  RST_FAST_PHASES = 6'd12;
	localparam logic [SLICE_W-1:0]  RST_SLOW_SLICES = 6'd22;
	localparam logic [SLICE_W-1:0]  RST_SLOW_PHASES = 6'd22;

	localparam logic [CNT_W-1:0]   COUNT_MAX  = 11'd2047;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
	localparam logic [DIGIT_W-1:0] LOW_DIGIT_OTHER = 4'd6;

	// x / 100 for 12-bit x as (x * 5243) >> 19
	localparam int DIV100_MUL_W = 13;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam int QUOT100_W    = 6;

	localparam logic [2:0]   AP_DIGIT_POS [AP_POS] = '{3'd0, 3'd2, 3'd4};
	localparam logic [6:0]   AP_OFFS      [AP_POS] = '{7'd0, 7'd33, 7'd66};

	// 1-based bit numbers of each digit for positions 0, 2 and 4
	localparam logic [6:0] PULSE_BIT [AP_POS][10] = '{
		'{7'd57, 7'd41, 7'd25, 7'd9,  7'd58, 7'd42, 7'd26, 7'd10, 7'd59, 7'd43},
		'{7'd62, 7'd46, 7'd30, 7'd14, 7'd63, 7'd47, 7'd31, 7'd15, 7'd64, 7'd48},
		'{7'd19, 7'd3,  7'd52, 7'd36, 7'd20, 7'd4,  7'd53, 7'd37, 7'd21, 7'd5}
	};

	function automatic logic [BIT_IDX_W-1:0] pulse_bit_idx(input logic [1:0] p,
		input logic [DIGIT_W-1:0] d);
		logic [6:0] b;
		b = 7'd1;
		if (p < 2'(AP_POS) && d <= DIGIT_MAX) begin
			b = PULSE_BIT[p][d];
		end
		return BIT_IDX_W'(b - 7'd1);
	endfunction

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic             tick;
		logic             advance;
		logic             set_dis;
		logic [DIS_W-1:0] dis;
	} ap_ctrl_t;

endpackage

FILE: hw/rtl/nbc_if.sv
// Handshake channels of the nixie blend compositor: command in, result out.
// Depends on nbc_pkg.
interface nbc_cmd_if;
	logic                        valid;
	logic                        ready;
	nbc_pkg::op_t                op;
	logic [nbc_pkg::CHAN_W-1:0]  channel;
	logic [nbc_pkg::WORD_W-1:0]  new_word;
	logic [nbc_pkg::WORD_W-1:0]  new_mask;
	logic [nbc_pkg::DIS_W-1:0]   digit_disable;

	modport source (output valid, op, channel, new_word, new_mask, digit_disable,
		input ready);
	modport sink (input valid, op, channel, new_word, new_mask, digit_disable,
		output ready);
endinterface

interface nbc_res_if;
	logic                        valid;
	logic                        ready;
	logic [nbc_pkg::WORD_W-1:0]  shift_word;
	logic [nbc_pkg::FLAG_W-1:0]  blending_flags;

	modport source (output valid, shift_word, blending_flags, input ready);
	modport sink (input valid, shift_word, blending_flags, output ready);
endinterface

FILE: hw/rtl/nbc_divider.sv
// Restoring divider, one quotient bit per cycle: blend count by slices.
// Depends on nbc_pkg.
module nbc_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nbc_pkg::div_ctrl_t          ctrl,
	input  logic [nbc_pkg::CNT_W-1:0]   dividend,
	input  logic [nbc_pkg::SLICE_W-1:0] divisor,
	output nbc_pkg::div_stat_t          stat,
	output logic [nbc_pkg::CNT_W-1:0]   quotient,
	output logic [nbc_pkg::SLICE_W-1:0] remainder
);
	import nbc_pkg::*;

	localparam int STEP_W = $clog2(CNT_W + 1);

	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   quo_q;
	logic [SLICE_W-1:0] rem_q;
	logic [SLICE_W-1:0] den_q;
	logic [SLICE_W:0]   trial;
	logic               ge;

	always_comb begin
		trial = {rem_q, quo_q[CNT_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				step_q <= STEP_W'(CNT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT_W-2:0], ge};
			rem_q <= ge ? SLICE_W'(trial - {1'b0, den_q}) : trial[SLICE_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/nbc_ap_unit.sv
// Anti-poisoning: tick counter, cycled digits, disable flags and pulse word.
// Depends on nbc_pkg.
module nbc_ap_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nbc_pkg::ap_ctrl_t            ctrl,
	input  logic [nbc_pkg::LEVEL_W-1:0]  ap_level,
	input  logic [nbc_pkg::PERIOD_W-1:0] ap_period,
	input  logic [nbc_pkg::DIGIT_W-1:0]  ht_low_digit,
	output logic [nbc_pkg::WORD_W-1:0]   pulses
);
	import nbc_pkg::*;

	localparam int PROD_W  = PERIOD_W + DIV100_MUL_W;
	localparam int START_W = PERIOD_W + 1;

	logic [PERIOD_W-1:0]  count_q;
	logic [DIGIT_W-1:0]   digit_q [AP_POS];
	logic [DIS_W-1:0]     dis_q;
	logic [QUOT100_W-1:0] quot_q;
	logic [START_W-1:0]   start_q [AP_POS];
	logic [PROD_W-1:0]    div_prod;
	logic [PERIOD_W:0]    count_inc;

	assign div_prod  = PROD_W'(ap_period) * PROD_W'(DIV100_MUL);
	assign count_inc = {1'b0, count_q} + 1'b1;

	// start offsets follow a period write through quot_q and then start_q
	always_ff @(posedge clk) begin
		quot_q <= div_prod[DIV100_SHIFT +: QUOT100_W];
		for (int p = 0; p < AP_POS; p++) begin
			start_q[p] <= START_W'(quot_q) * START_W'(AP_OFFS[p]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			digit_q[0] <= RST_HT_LOW;
			for (int p = 1; p < AP_POS; p++) begin
				digit_q[p] <= LOW_DIGIT_OTHER;
			end
			dis_q <= '0;
		end else begin
			if (ctrl.tick) begin
				count_q <= (count_inc >= {1'b0, ap_period}) ? '0 : count_inc[PERIOD_W-1:0];
			end
			if (ctrl.advance) begin
				for (int p = 0; p < AP_POS; p++) begin
					if ({1'b0, digit_q[p]} + 5'd1 > {1'b0, DIGIT_MAX}) begin
						digit_q[p] <= (p == 0) ? ht_low_digit : LOW_DIGIT_OTHER;
					end else begin
						digit_q[p] <= digit_q[p] + 1'b1;
					end
				end
			end
			if (ctrl.set_dis) begin
				dis_q <= ctrl.dis;
			end
		end
	end

	always_comb begin
		logic [START_W:0] win_end;
		logic             hit;
		pulses = '0;
		for (int p = 0; p < AP_POS; p++) begin
			win_end = {1'b0, start_q[p]} + (START_W + 1)'(ap_level);
			hit = !dis_q[AP_DIGIT_POS[p]] && (digit_q[p] <= DIGIT_MAX)
				&& ((START_W + 1)'(count_q) >= {1'b0, start_q[p]})
				&& ((START_W + 1)'(count_q) < win_end);
			if (hit) begin
				pulses[pulse_bit_idx(2'(p), digit_q[p])] = 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/nixie_blend_compositor.sv
// Nixie blend compositor top level: command/result channels, config port,
// blend sequencer. Depends on nbc_pkg, nbc_if, nbc_divider, nbc_ap_unit.
//
// Load, advance and disable commands are done when taken and give no result. A
// tick scans each blend channel in turn; for each active one it runs the shared
// 11-step divider, which splits the blend count into phase and slice, and then
// evaluates the channel. It then leaves its word in the output register; the
// next command is taken while that word waits. A tick that finishes while the
// previous result is still untaken waits for it.
module nixie_blend_compositor #(
	parameter int BLEND_CHANNELS = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nbc_cmd_if.sink                        cmd,
	nbc_res_if.source                      res,
	input  logic                           wr_en,
	input  logic [nbc_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [nbc_pkg::REG_DATA_W-1:0] wr_data
);
	import nbc_pkg::*;

	localparam int CH_W = (BLEND_CHANNELS > 1) ? $clog2(BLEND_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_AP   = 3'd4;

	// config registers
	logic [LEVEL_W-1:0]  ap_level_q;
	logic [PERIOD_W-1:0] ap_period_q;
	logic [DIGIT_W-1:0]  ht_low_q;
	logic [SHIFT_W-1:0]  blend_shift_q;
	logic [SLICE_W-1:0]  fast_slices_q;
	logic [SLICE_W-1:0]  fast_phases_q;
	logic [SLICE_W-1:0]  slow_slices_q;
	logic [SLICE_W-1:0]  slow_phases_q;

	logic [2:0]          state_q;
	logic [CH_W-1:0]     ch_q;
	logic                blend_on_q    [BLEND_CHANNELS];
	logic [WORD_W-1:0]   blend_word_q  [BLEND_CHANNELS];
	logic [WORD_W-1:0]   blend_mask_q  [BLEND_CHANNELS];
	logic [CNT_W-1:0]    blend_count_q [BLEND_CHANNELS];
	logic [WORD_W-1:0]   shown_word_q;
	logic [WORD_W-1:0]   acc_q;
	logic [FLAG_W-1:0]   flags_q;
	logic                res_valid_q;
	logic [WORD_W-1:0]   res_word_q;
	logic [FLAG_W-1:0]   res_flags_q;

	logic                cmd_fire;
	logic                res_free;
	logic                chan_ok;
	logic [CH_W-1:0]     chan_idx;
	logic                last_ch;
	logic [FLAG_W-1:0]   on_vec;
	logic [SLICE_W-1:0]  slices_raw;
	logic [SLICE_W-1:0]  phases_raw;
	logic [SLICE_W-1:0]  slices_eff;
	logic [SLICE_W-1:0]  phases_eff;
	logic [14:0]         shift_prod;
	logic                take_new;
	logic [11:0]         limit_raw;
	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    cnt_next;
	logic                blend_end;
	logic [WORD_W-1:0]   acc_blend;
	logic [WORD_W-1:0]   acc_next;
	logic [WORD_W-1:0]   pulses;

	div_ctrl_t           div_ctrl;
	div_stat_t           div_stat;
	logic [CNT_W-1:0]    div_quo;
	logic [SLICE_W-1:0]  div_rem;
	ap_ctrl_t            ap_ctrl;

	for (genvar gc = 0; gc < FLAG_W; gc++) begin : g_flags
		if (gc < BLEND_CHANNELS) begin : g_on
			assign on_vec[gc] = blend_on_q[gc];
		end else begin : g_off
			assign on_vec[gc] = 1'b0;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign res_free  = !res_valid_q || res.ready;

	assign chan_ok  = (cmd.channel != '0) && ({1'b0, cmd.channel} <= 3'(BLEND_CHANNELS));
	assign chan_idx = CH_W'(cmd.channel - 2'd1);
	assign last_ch  = (ch_q == CH_W'(BLEND_CHANNELS - 1));

	always_comb begin
		slices_raw = (ch_q == '0) ? fast_slices_q : slow_slices_q;
		phases_raw = (ch_q == '0) ? fast_phases_q : slow_phases_q;
		slices_eff = (slices_raw == '0) ? SLICE_W'(1) : slices_raw;
		phases_eff = (phases_raw == '0) ? SLICE_W'(1) : phases_raw;

		// slice >= slices - shift*phase, kept unsigned
		shift_prod = 15'(blend_shift_q) * 15'(div_quo);
		take_new   = (16'(div_rem) + 16'(shift_prod)) >= 16'(slices_eff);

		limit_raw = 12'(phases_eff) * 12'(slices_eff);
		limit     = (limit_raw > 12'(COUNT_MAX)) ? COUNT_MAX : limit_raw[CNT_W-1:0];
		cnt_next  = blend_count_q[ch_q] + 1'b1;
		blend_end = cnt_next >= limit;

		acc_blend = (acc_q & ~blend_mask_q[ch_q]) | (blend_word_q[ch_q] & blend_mask_q[ch_q]);
		acc_next  = take_new ? acc_blend : acc_q;
	end

	assign div_ctrl.start = (state_q == ST_SCAN) && blend_on_q[ch_q];

	assign ap_ctrl.tick    = (state_q == ST_AP) && res_free && (ap_level_q != '0);
	assign ap_ctrl.advance = cmd_fire && (cmd.op == OP_ADVANCE) && (ap_level_q != '0);
	assign ap_ctrl.set_dis = cmd_fire && (cmd.op == OP_SET_DIS);
	assign ap_ctrl.dis     = cmd.digit_disable;

	nbc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (blend_count_q[ch_q]),
		.divisor   (slices_eff),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	nbc_ap_unit u_ap (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ap_ctrl),
		.ap_level     (ap_level_q),
		.ap_period    (ap_period_q),
		.ht_low_digit (ht_low_q),
		.pulses       (pulses)
	);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_level_q    <= RST_AP_LEVEL;
			ap_period_q   <= RST_AP_PERIOD;
			ht_low_q      <= RST_HT_LOW;
			blend_shift_q <= RST_BLEND_SHIFT;
			fast_slices_q <= RST_FAST_SLICES;
			fast_phases_q <= RST_FAST_PHASES;
			slow_slices_q <= RST_SLOW_SLICES;
			slow_phases_q <= RST_SLOW_PHASES;
		end else if (wr_en) begin
			case (wr_index)
				REG_AP_LEVEL:    ap_level_q    <= wr_data[LEVEL_W-1:0];
				REG_AP_PERIOD:   ap_period_q   <= wr_data[PERIOD_W-1:0];
				REG_HT_LOW:      ht_low_q      <= wr_data[DIGIT_W-1:0];
				REG_BLEND_SHIFT: blend_shift_q <= wr_data[SHIFT_W-1:0];
				REG_FAST_SLICES: fast_slices_q <= wr_data[SLICE_W-1:0];
				REG_FAST_PHASES: fast_phases_q <= wr_data[SLICE_W-1:0];
				REG_SLOW_SLICES: slow_slices_q <= wr_data[SLICE_W-1:0];
				REG_SLOW_PHASES: slow_phases_q <= wr_data[SLICE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ch_q         <= '0;
			flags_q      <= '0;
			shown_word_q <= '0;
			res_valid_q  <= 1'b0;
			for (int c = 0; c < BLEND_CHANNELS; c++) begin
				blend_on_q[c] <= 1'b0;
			end
		end else begin
			if ((state_q == ST_AP) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.op)
							OP_TICK: begin
								ch_q    <= '0;
								flags_q <= on_vec;
								state_q <= ST_SCAN;
							end
							OP_LOAD: begin
								if (cmd.channel == '0) begin
									shown_word_q <= cmd.new_word;
									for (int c = 0; c < BLEND_CHANNELS; c++) begin
										blend_on_q[c] <= 1'b0;
									end
								end else if (chan_ok) begin
									blend_on_q[chan_idx] <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (blend_on_q[ch_q]) begin
						state_q <= ST_DIV;
					end else if (last_ch) begin
						state_q <= ST_AP;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (blend_end) begin
						blend_on_q[ch_q] <= 1'b0;
						shown_word_q     <= acc_next;
					end
					if (last_ch) begin
						state_q <= ST_AP;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_AP: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd_fire && (cmd.op == OP_TICK)) begin
			acc_q <= shown_word_q;
		end
		if (cmd_fire && (cmd.op == OP_LOAD) && chan_ok) begin
			blend_word_q[chan_idx]  <= cmd.new_word;
			blend_mask_q[chan_idx]  <= cmd.new_mask;
			blend_count_q[chan_idx] <= '0;
		end
		if (state_q == ST_EVAL) begin
			acc_q               <= acc_next;
			blend_count_q[ch_q] <= cnt_next;
		end
		if ((state_q == ST_AP) && res_free) begin
			res_word_q  <= (ap_level_q != '0) ? (acc_q | pulses) : acc_q;
			res_flags_q <= flags_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.shift_word     = res_word_q;
	assign res.blending_flags = res_flags_q;

endmodule

FILE: hw/rtl/nbc_checker.sv
// Port-level checker for the nixie blend compositor, bound to the top level.
// Depends on nbc_pkg and nixie_blend_compositor_assert.svh.
`include "nixie_blend_compositor_assert.svh"

module nbc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input nbc_pkg::op_t               cmd_op,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [nbc_pkg::WORD_W-1:0] res_shift_word
);
	import nbc_pkg::*;

	// a tick holds the command side off while it works
	`NBC_ASSERT_NXT(a_tick_busy, cmd_valid && cmd_ready && cmd_op == OP_TICK, !cmd_ready)
	// other commands finish in the cycle they are taken
	`NBC_ASSERT_NXT(a_cmd_done, cmd_valid && cmd_ready && cmd_op != OP_TICK, cmd_ready)
	// a new result only comes out of tick work
	`NBC_ASSERT_IMP(a_res_from_tick, $rose(res_valid), !$past(cmd_ready))
	`NBC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_shift_word))

endmodule

bind nixie_blend_compositor nbc_checker u_nbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_shift_word (res.shift_word)
);
